// ----- sv/rau_pkg.sv -----
// shared types, constants and helpers for the rational arithmetic unit
package rau_pkg;
   localparam int OPERAND_WIDTH = 16;
   localparam int MAG_W = 2 * OPERAND_WIDTH + 1;
   localparam int NUM_W = 33;
   localparam int DEN_W = 31;
   localparam int CNT_W = $clog2(MAG_W + 1);

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                    command;
      logic signed [OPERAND_WIDTH-1:0] num_a;
      logic signed [OPERAND_WIDTH-1:0] den_a;
      logic signed [OPERAND_WIDTH-1:0] num_b;
      logic signed [OPERAND_WIDTH-1:0] den_b;
   } req_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] res_num;
      logic [DEN_W-1:0]        res_den;
      logic                    status;
   } rsp_type;

   // classified operands: sign flags and magnitudes
   typedef struct packed {
      cmd_type                  command;
      logic                     na, nb, nc, nd;
      logic [OPERAND_WIDTH-1:0] a, b, c, d;
   } work_type;

   function automatic logic [OPERAND_WIDTH-1:0] mag_of(
         input logic [OPERAND_WIDTH-1:0] v);
      mag_of = v[OPERAND_WIDTH-1] ? (~v + 1'b1) : v;
   endfunction
endpackage

// ----- sv/rau_if.sv -----
// valid/ready channel interfaces
interface rau_req_if;
   import rau_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface rau_rsp_if;
   import rau_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- sv/rau_front.sv -----
// front end: takes requests, splits operands into sign and magnitude, two-entry queue
module rau_front import rau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   rau_req_if.sink  req,
   output logic     work_valid,
   input  logic     work_ready,
   output work_type work
);
   work_type   q_ff [2];
   work_type   entry;
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign req.ready  = cnt_ff != 2'd2;
   assign push       = req.valid && req.ready;
   assign work_valid = cnt_ff != 2'd0;
   assign pop        = work_valid && work_ready;
   assign work       = q_ff[rd_ff];

   always_comb begin
      entry.command = req.data.command;
      entry.na = req.data.num_a[OPERAND_WIDTH-1];
      entry.nb = req.data.den_a[OPERAND_WIDTH-1];
      entry.nc = req.data.num_b[OPERAND_WIDTH-1];
      entry.nd = req.data.den_b[OPERAND_WIDTH-1];
      entry.a  = mag_of(req.data.num_a);
      entry.b  = mag_of(req.data.den_a);
      entry.c  = mag_of(req.data.num_b);
      entry.d  = mag_of(req.data.den_b);
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wr_ff] <= entry;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !push) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !pop) else $error("queue underflow");
   a_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("count slip");
endmodule

// ----- sv/rau_back.sv -----
// back end: sequencer with shared multiplier and restoring divider, gcd by remainders
module rau_back import rau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     work_valid,
   output logic     work_ready,
   input  work_type work,
   rau_rsp_if.source rsp
);
   typedef enum logic [3:0] {
      S_IDLE, S_G1, S_DEN1, S_T1, S_T2, S_SUM, S_MUL1, S_MUL2,
      S_G2, S_RN, S_RD, S_OUT
   } state_type;

   state_type        state_ff;
   work_type         w_ff;
   logic [MAG_W-1:0] x_ff, y_ff;      // gcd operands
   logic [MAG_W-1:0] g_ff, bq_ff, dq_ff, den_ff, nmag_ff, t1_ff;
   logic             neg_ff, ret_ff;
   // divider
   logic             dbusy_ff;
   logic [MAG_W-1:0] dq_r_ff, drem_ff, ddiv_ff;
   logic [CNT_W-1:0] dcnt_ff;
   logic [MAG_W:0]   trial;
   logic [MAG_W-1:0] rem_sh;
   logic [MAG_W-1:0] prod;
   logic [MAG_W-1:0] ma, mb;
   logic             t1n, t2n;
   rsp_type          out_ff;
   logic             ovalid_ff;

   assign work_ready = state_ff == S_IDLE;
   assign rsp.valid  = ovalid_ff;
   assign rsp.data   = out_ff;
   assign prod       = MAG_W'(ma[OPERAND_WIDTH*2-1:0] * mb[OPERAND_WIDTH*2-1:0]);
   assign rem_sh     = {drem_ff[MAG_W-2:0], dq_r_ff[MAG_W-1]};
   assign trial      = {1'b0, rem_sh} - {1'b0, ddiv_ff};

   always_comb begin
      ma = '0; mb = '0;
      t1n = w_ff.na ^ w_ff.nb;
      t2n = (w_ff.nc ^ w_ff.nd) ^ (w_ff.command == CMD_SUB);
      unique case (state_ff)
         S_DEN1:  begin ma = bq_ff; mb = MAG_W'(w_ff.d); end
         S_T1:    begin ma = MAG_W'(w_ff.a); mb = dq_ff; end
         S_T2:    begin ma = MAG_W'(w_ff.c); mb = bq_ff; end
         S_MUL1:  begin
            ma = MAG_W'(w_ff.a);
            mb = MAG_W'((w_ff.command == CMD_MUL) ? w_ff.c : w_ff.d);
         end
         S_MUL2:  begin
            ma = MAG_W'(w_ff.b);
            mb = MAG_W'((w_ff.command == CMD_MUL) ? w_ff.d : w_ff.c);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         dbusy_ff  <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) ovalid_ff <= 1'b0;
         if (dbusy_ff) begin
            if (trial[MAG_W]) drem_ff <= rem_sh;
            else drem_ff <= trial[MAG_W-1:0];
            dq_r_ff <= {dq_r_ff[MAG_W-2:0], ~trial[MAG_W]};
            dcnt_ff <= dcnt_ff - 1'b1;
            if (dcnt_ff == CNT_W'(1)) dbusy_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: if (work_valid) begin
               w_ff <= work;
               if (work.command == CMD_ADD || work.command == CMD_SUB) begin
                  if (work.b != '0 && work.d != '0) begin
                     x_ff <= MAG_W'(work.b); y_ff <= MAG_W'(work.d);
                     ret_ff <= 1'b0; state_ff <= S_G1;
                  end else begin
                     g_ff <= MAG_W'(1); den_ff <= '0;
                     bq_ff <= MAG_W'(work.b); dq_ff <= MAG_W'(work.d);
                     ret_ff <= 1'b0;
                     state_ff <= S_T1;
                  end
               end else state_ff <= S_MUL1;
            end
            S_G1, S_G2: if (!dbusy_ff) begin
               // one remainder per pass; divider result ready when idle
               if (y_ff == '0) begin
                  g_ff <= x_ff;
                  if (state_ff == S_G1) begin
                     dq_r_ff <= MAG_W'(w_ff.b); ddiv_ff <= x_ff;
                     drem_ff <= '0; dcnt_ff <= CNT_W'(MAG_W); dbusy_ff <= 1'b1;
                     ret_ff <= 1'b1;
                     state_ff <= S_DEN1;
                  end else begin
                     dq_r_ff <= nmag_ff; ddiv_ff <= x_ff;
                     drem_ff <= '0; dcnt_ff <= CNT_W'(MAG_W); dbusy_ff <= 1'b1;
                     state_ff <= S_RN;
                  end
               end else if (!ret_ff) begin
                  dq_r_ff <= x_ff; ddiv_ff <= y_ff; drem_ff <= '0;
                  dcnt_ff <= CNT_W'(MAG_W); dbusy_ff <= 1'b1; ret_ff <= 1'b1;
               end else begin
                  x_ff <= y_ff; y_ff <= drem_ff; ret_ff <= 1'b0;
               end
            end
            S_DEN1: if (!dbusy_ff) begin
               if (ret_ff) begin
                  bq_ff <= dq_r_ff;
                  dq_r_ff <= MAG_W'(w_ff.d); ddiv_ff <= g_ff; drem_ff <= '0;
                  dcnt_ff <= CNT_W'(MAG_W); dbusy_ff <= 1'b1; ret_ff <= 1'b0;
               end else begin
                  dq_ff <= dq_r_ff; ret_ff <= 1'b1;
                  state_ff <= S_T1;
               end
            end
            S_T1: begin
               if (ret_ff) den_ff <= MAG_W'(bq_ff[OPERAND_WIDTH-1:0] * w_ff.d);
               t1_ff <= prod; state_ff <= S_T2;
            end
            S_T2: begin
               if (t1n == t2n) begin nmag_ff <= t1_ff + prod; neg_ff <= t1n; end
               else if (t1_ff >= prod) begin nmag_ff <= t1_ff - prod; neg_ff <= t1n; end
               else begin nmag_ff <= prod - t1_ff; neg_ff <= t2n; end
               state_ff <= S_SUM;
            end
            S_SUM: begin
               x_ff <= nmag_ff; y_ff <= den_ff; ret_ff <= 1'b0;
               state_ff <= (nmag_ff == '0) ? S_OUT : S_G2;
            end
            S_MUL1: begin
               nmag_ff <= prod; state_ff <= S_MUL2;
               neg_ff <= (w_ff.na ^ w_ff.nb) ^ (w_ff.nc ^ w_ff.nd);
            end
            S_MUL2: begin den_ff <= prod; state_ff <= S_SUM; end
            S_RN: if (!dbusy_ff) begin
               nmag_ff <= dq_r_ff;
               dq_r_ff <= den_ff; ddiv_ff <= g_ff; drem_ff <= '0;
               dcnt_ff <= CNT_W'(MAG_W); dbusy_ff <= 1'b1;
               state_ff <= S_RD;
            end
            S_RD: if (!dbusy_ff) begin
               den_ff <= dq_r_ff; state_ff <= S_OUT;
            end
            S_OUT: if (!ovalid_ff) begin
               if (nmag_ff == '0) begin
                  out_ff.res_num <= '0; out_ff.res_den <= DEN_W'(1);
                  out_ff.status <= 1'b0;
               end else begin
                  out_ff.res_num <= neg_ff ? NUM_W'(~nmag_ff + 1'b1) : NUM_W'(nmag_ff);
                  out_ff.res_den <= DEN_W'(den_ff);
                  out_ff.status  <= den_ff == '0;
               end
               ovalid_ff <= 1'b1; state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && !rsp.ready) |=> ovalid_ff) else $error("result dropped");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !dbusy_ff) else $error("divider busy at idle");
   a_one_den: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && out_ff.status) |-> out_ff.res_den == '0) else $error("bad infinity");
endmodule

// ----- sv/rational_arithmetic_unit.sv -----
// Rational arithmetic unit: add, subtract, multiply or divide two signed
// fractions and reduce the result to lowest terms, sign on the numerator.
// The back end runs every gcd remainder and every exact quotient through one
// shared restoring divider, for the lcm of the denominators and for the reduction.
// A two-entry queue lets the next requests be taken while one is in work.
module rational_arithmetic_unit import rau_pkg::*; (
   input logic       clock,
   input logic       reset,
   rau_req_if.sink   req,
   rau_rsp_if.source rsp
);
   logic     work_valid, work_ready;
   work_type work;

   rau_front u_front (.clock, .reset, .req, .work_valid, .work_ready, .work);
   rau_back  u_back  (.clock, .reset, .work_valid, .work_ready, .work, .rsp);
endmodule
